/* rtl/core/integer_matrix_multiply_core_macros.svh */
// Assertion helpers used by the matrix multiply controller.
// Both expect clk and arst_n in scope.
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH

// same-cycle implication
`define IMM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/imm_pkg.sv */
`default_nettype none
package imm_pkg;

	localparam logic [1:0] CMD_WRITE_A = 2'd0;
	localparam logic [1:0] CMD_WRITE_B = 2'd1;
	localparam logic [1:0] CMD_RUN     = 2'd2;

	localparam int ELEM_W = 16;
	localparam int PROD_W = 32;
	localparam int SUM_W  = 35;

	typedef struct packed {
		logic [1:0]               cmd;
		logic [1:0]               row;
		logic [1:0]               col;
		logic signed [ELEM_W-1:0] element;
	} imm_in_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] product_value;
		logic [1:0]              out_row;
		logic [1:0]              out_col;
		logic                    last;
	} imm_out_t;

	// controller -> datapath
	typedef struct packed {
		logic mac_issue;   // read one A/B pair and feed the MAC
		logic first;       // first term of a dot product
		logic last;        // final term of a dot product
		logic load_out;    // move finished sum into the output register
		logic last_entry;  // entry being loaded is the final one of the run
	} imm_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic acc_done;    // accumulator holds a complete dot product
		logic out_free;    // output register can take a new entry this cycle
	} imm_sts_t;

endpackage
`default_nettype wire

/* rtl/core/imm_stream_if.sv */
`default_nettype none
interface imm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/imm_datapath.sv */
`default_nettype none
module imm_datapath
	import imm_pkg::*;
#(
	parameter int ROWS_LEFT  = 4,
	parameter int INNER_DIM  = 4,
	parameter int COLS_RIGHT = 4,
	parameter int IW = (ROWS_LEFT  > 1) ? $clog2(ROWS_LEFT)  : 1,
	parameter int KW = (INNER_DIM  > 1) ? $clog2(INNER_DIM)  : 1,
	parameter int JW = (COLS_RIGHT > 1) ? $clog2(COLS_RIGHT) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire imm_in_t       wr_item,
	input  wire logic [IW-1:0] row_idx,
	input  wire logic [JW-1:0] col_idx,
	input  wire logic [KW-1:0] k_idx,
	input  wire imm_ctl_t      ctl,
	output imm_sts_t           sts,
	input  wire logic          out_ready,
	output logic               out_valid,
	output imm_out_t           out_item
);

	localparam int A_DEPTH = ROWS_LEFT * INNER_DIM;
	localparam int B_DEPTH = INNER_DIM * COLS_RIGHT;
	localparam int AAW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

	logic signed [ELEM_W-1:0] mem_a [A_DEPTH];
	logic signed [ELEM_W-1:0] mem_b [B_DEPTH];

	logic           we_a, we_b;
	logic [AAW-1:0] wa_addr, ra_addr;
	logic [BAW-1:0] wb_addr, rb_addr;

	logic signed [ELEM_W-1:0] a_s1, b_s1;
	logic                     valid_s1, first_s1, last_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2, first_s2, last_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     acc_done_q;
	logic                     out_valid_q;
	imm_out_t                 out_q;

	// writes outside the configured shape are dropped
	assign we_a = wr_en && (wr_item.cmd == CMD_WRITE_A)
		&& (32'(wr_item.row) < ROWS_LEFT) && (32'(wr_item.col) < INNER_DIM);
	assign we_b = wr_en && (wr_item.cmd == CMD_WRITE_B)
		&& (32'(wr_item.row) < INNER_DIM) && (32'(wr_item.col) < COLS_RIGHT);

	assign wa_addr = AAW'(int'(wr_item.row) * INNER_DIM + int'(wr_item.col));
	assign wb_addr = BAW'(int'(wr_item.row) * COLS_RIGHT + int'(wr_item.col));
	assign ra_addr = AAW'(int'(row_idx) * INNER_DIM + int'(k_idx));
	assign rb_addr = BAW'(int'(k_idx) * COLS_RIGHT + int'(col_idx));

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wa_addr] <= wr_item.element;
		end
		if (we_b) begin
			mem_b[wb_addr] <= wr_item.element;
		end
		a_s1 <= mem_a[ra_addr];
		b_s1 <= mem_b[rb_addr];
		first_s1 <= ctl.first;
		last_s1  <= ctl.last;
		prod_s2  <= a_s1 * b_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.mac_issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= first_s2 ? SUM_W'(prod_s2) : acc_q + SUM_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_done_q <= 1'b0;
		end else if (valid_s2 && last_s2) begin
			acc_done_q <= 1'b1;
		end else if (ctl.load_out) begin
			acc_done_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q.product_value <= acc_q;
			out_q.out_row       <= 2'(row_idx);
			out_q.out_col       <= 2'(col_idx);
			out_q.last          <= ctl.last_entry;
		end
	end

	assign sts.acc_done = acc_done_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_item     = out_q;

endmodule
`default_nettype wire

/* rtl/core/imm_controller.sv */
`default_nettype none
`include "integer_matrix_multiply_core_macros.svh"
module imm_controller
	import imm_pkg::*;
#(
	parameter int ROWS_LEFT  = 4,
	parameter int INNER_DIM  = 4,
	parameter int COLS_RIGHT = 4,
	parameter int IW = (ROWS_LEFT  > 1) ? $clog2(ROWS_LEFT)  : 1,
	parameter int KW = (INNER_DIM  > 1) ? $clog2(INNER_DIM)  : 1,
	parameter int JW = (COLS_RIGHT > 1) ? $clog2(COLS_RIGHT) : 1
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          idle,
	output logic [IW-1:0] row_idx,
	output logic [JW-1:0] col_idx,
	output logic [KW-1:0] k_idx,
	output imm_ctl_t      ctl,
	input  wire imm_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MAC  = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	localparam logic [IW-1:0] I_LAST = IW'(ROWS_LEFT - 1);
	localparam logic [KW-1:0] K_LAST = KW'(INNER_DIM - 1);
	localparam logic [JW-1:0] J_LAST = JW'(COLS_RIGHT - 1);

	state_t        state_q;
	logic [IW-1:0] i_q;
	logic [JW-1:0] j_q;
	logic [KW-1:0] k_q;
	logic          k_end, entry_end, load;

	assign k_end     = (k_q == K_LAST);
	assign entry_end = (i_q == I_LAST) && (j_q == J_LAST);
	assign load      = (state_q == ST_WAIT) && sts.acc_done && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_end) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_WAIT: begin
					if (load) begin
						if (entry_end) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_MAC;
							if (j_q == J_LAST) begin
								j_q <= '0;
								i_q <= i_q + IW'(1);
							end else begin
								j_q <= j_q + JW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl.mac_issue  = (state_q == ST_MAC);
		ctl.first      = (state_q == ST_MAC) && (k_q == '0);
		ctl.last       = (state_q == ST_MAC) && k_end;
		ctl.load_out   = load;
		ctl.last_entry = entry_end;
	end

	assign idle    = (state_q == ST_IDLE);
	assign row_idx = i_q;
	assign col_idx = j_q;
	assign k_idx   = k_q;

	`IMM_ASSERT_NEXT(a_start_runs, idle && start, state_q == ST_MAC, "run did not start")
	`IMM_ASSERT_NOW(a_load_ready, ctl.load_out, sts.acc_done && sts.out_free, "load while busy")
	`IMM_ASSERT_NEXT(a_final_idle, ctl.load_out && ctl.last_entry, state_q == ST_IDLE, "no idle after run")

endmodule
`default_nettype wire

/* rtl/core/integer_matrix_multiply_core.sv */
// Timing: a load item is written into its store when accepted. A run item walks
// every entry in turn: INNER_DIM multiply-accumulates, one MAC per cycle, then the
// read, multiply and accumulate stages drain and the sum moves to the output
// register once that register is free. No new item is taken until the run ends.
// Reset: arst_n clears control state only; matrix stores hold garbage until written.
`default_nettype none
module integer_matrix_multiply_core
	import imm_pkg::*;
#(
	parameter int ROWS_LEFT  = 4,
	parameter int INNER_DIM  = 4,
	parameter int COLS_RIGHT = 4
) (
	input wire logic     clk,
	input wire logic     arst_n,
	imm_stream_if.sink   items,
	imm_stream_if.source products
);

	localparam int IW = (ROWS_LEFT  > 1) ? $clog2(ROWS_LEFT)  : 1;
	localparam int KW = (INNER_DIM  > 1) ? $clog2(INNER_DIM)  : 1;
	localparam int JW = (COLS_RIGHT > 1) ? $clog2(COLS_RIGHT) : 1;

	imm_in_t       in_item;
	imm_out_t      out_item;
	logic          in_accept;
	logic          start;
	logic          idle;
	logic [IW-1:0] row_idx;
	logic [JW-1:0] col_idx;
	logic [KW-1:0] k_idx;
	imm_ctl_t      ctl;
	imm_sts_t      sts;

	// Items are taken only while the sequencer is idle. Writes land in the
	// stores right away; a run item kicks off the walk over all entries.
	// A finished entry waiting in the output register does not block intake.
	assign in_item     = items.data;
	assign items.ready = idle;
	assign in_accept   = items.valid && idle;
	assign start       = in_accept && (in_item.cmd == CMD_RUN);

	// Sequencer: walks i, j and k, one multiply-accumulate per cycle while in ST_MAC; it waits in ST_WAIT for each load.
	imm_controller #(
		.ROWS_LEFT (ROWS_LEFT),
		.INNER_DIM (INNER_DIM),
		.COLS_RIGHT(COLS_RIGHT),
		.IW        (IW),
		.KW        (KW),
		.JW        (JW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.idle   (idle),
		.row_idx(row_idx),
		.col_idx(col_idx),
		.k_idx  (k_idx),
		.ctl    (ctl),
		.sts    (sts)
	);

	// Datapath: A/B stores, registered reads, multiplier, accumulator, output reg.
	imm_datapath #(
		.ROWS_LEFT (ROWS_LEFT),
		.INNER_DIM (INNER_DIM),
		.COLS_RIGHT(COLS_RIGHT),
		.IW        (IW),
		.KW        (KW),
		.JW        (JW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_accept),
		.wr_item  (in_item),
		.row_idx  (row_idx),
		.col_idx  (col_idx),
		.k_idx    (k_idx),
		.ctl      (ctl),
		.sts      (sts),
		.out_ready(products.ready),
		.out_valid(products.valid),
		.out_item (out_item)
	);

	assign products.data = out_item;

endmodule
`default_nettype wire
